@@ hdl/psf_pkg.sv @@
// Shared types and constants for the peak start candidate finder.
// No dependencies; every other file in hdl/ imports this package.
package psf_pkg;

  localparam int RECORD_LENGTH_MAX_DEF = 4096;
  localparam int START_STORE_DEPTH_DEF = 64;
  localparam int SAMPLE_BITS_DEF       = 16;

  localparam int SAMPLE_IN_W = 16;
  localparam int THR_W       = 16;
  localparam int MARGIN_W    = 8;
  localparam int WIN_W       = 10;
  localparam int NEAR_W      = 6;
  localparam int PRE_W       = 12;
  localparam int START_W     = 12;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [THR_W-1:0]    THR_RESET      = 16'd35;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET   = 8'd8;
  localparam logic [WIN_W-1:0]    LOOKBACK_RESET = 10'd220;
  localparam logic [WIN_W-1:0]    FALLBACK_RESET = 10'd24;
  localparam logic [NEAR_W-1:0]   NEAR_RESET     = 6'd6;

  localparam logic OP_PRELOAD = 1'b0;
  localparam logic OP_SAMPLE  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED_THRESHOLD  = 3'd0,
    REG_PEAK_MARGIN     = 3'd1,
    REG_LOOKBACK_WINDOW = 3'd2,
    REG_FALLBACK_OFFSET = 3'd3,
    REG_NEAR_DISTANCE   = 3'd4
  } psf_cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } psf_state_t;

  // Token and running near-hit flag that walk the cell row with a candidate.
  typedef struct packed {
    logic tok;
    logic hit;
  } psf_flag_t;

endpackage

@@ hdl/psf_cell.sv @@
// One cell of the start store row: holds one stored start and checks the
// passing candidate against it. Depends on psf_pkg.
module psf_cell #(
  parameter int CELL_INDEX = 0,
  parameter int ENTRY_W    = 12,
  parameter int CW         = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  psf_pkg::psf_flag_t        flag_in,
  input  logic [ENTRY_W-1:0]        cand_in,
  output psf_pkg::psf_flag_t        flag_out,
  output logic [ENTRY_W-1:0]        cand_out,
  input  logic [CW-1:0]             count,
  input  logic [psf_pkg::NEAR_W-1:0] near_dist,
  input  logic                      we,
  input  logic [ENTRY_W-1:0]        wdata
);
  import psf_pkg::*;

  psf_flag_t          flag_r;
  logic [ENTRY_W-1:0] cand_r;
  logic [ENTRY_W-1:0] entry_r;
  logic               occupied;
  logic [ENTRY_W-1:0] diff;
  logic               hit_here;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= '0;
    end else begin
      flag_r <= flag_in;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_in;
    if (we && count == CW'(CELL_INDEX)) begin
      entry_r <= wdata;
    end
  end

  always_comb begin
    occupied = CW'(CELL_INDEX) < count;
    diff     = (entry_r >= cand_r) ? (entry_r - cand_r) : (cand_r - entry_r);
    hit_here = occupied && (diff <= ENTRY_W'(near_dist));
    flag_out.tok = flag_r.tok;
    flag_out.hit = flag_r.hit | hit_here;
    cand_out     = cand_r;
  end

endmodule

@@ hdl/psf_chain.sv @@
// Row of start store cells; a candidate advances one cell per cycle.
// Depends on psf_pkg and psf_cell.
module psf_chain #(
  parameter int DEPTH   = 64,
  parameter int ENTRY_W = 12,
  parameter int CW      = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  psf_pkg::psf_flag_t         head_flag,
  input  logic [ENTRY_W-1:0]         head_cand,
  output psf_pkg::psf_flag_t         tail_flag,
  input  logic [CW-1:0]              count,
  input  logic [psf_pkg::NEAR_W-1:0] near_dist,
  input  logic                       we,
  input  logic [ENTRY_W-1:0]         wdata
);
  import psf_pkg::*;

  psf_flag_t          flags [DEPTH+1];
  logic [ENTRY_W-1:0] cands [DEPTH+1];

  assign flags[0]  = head_flag;
  assign cands[0]  = head_cand;
  assign tail_flag = flags[DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    psf_cell #(
      .CELL_INDEX (k),
      .ENTRY_W    (ENTRY_W),
      .CW         (CW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .flag_in   (flags[k]),
      .cand_in   (cands[k]),
      .flag_out  (flags[k+1]),
      .cand_out  (cands[k+1]),
      .count     (count),
      .near_dist (near_dist),
      .we        (we),
      .wdata     (wdata)
    );
  end

endmodule

@@ hdl/peak_start_candidate_finder.sv @@
// Top level of the peak start candidate finder: sample front end, control
// and result register. Depends on psf_pkg and psf_chain.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    op, sample_value, preload_position, last_sample
//   out_     output     out_valid/out_ready  start_index, from_crossing, store_full
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// A preload or a sample without a peak candidate leaves the block in ST_IDLE.
// A sample with a peak candidate moves it to ST_SCAN and then ST_FINISH: the
// candidate walks the cell row one cell per cycle, then, if no stored start was near, the result is loaded.
// A stalled out_ready holds the block in ST_FINISH only while the result register is occupied.
// Reset is synchronous; it zeroes the store fill count, with no clearing pass.
module peak_start_candidate_finder #(
  parameter int RECORD_LENGTH_MAX = psf_pkg::RECORD_LENGTH_MAX_DEF,
  parameter int START_STORE_DEPTH = psf_pkg::START_STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS       = psf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic signed [psf_pkg::SAMPLE_IN_W-1:0] in_sample_value,
  input  logic [psf_pkg::PRE_W-1:0]           in_preload_position,
  input  logic                                in_last_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [psf_pkg::START_W-1:0]         out_start_index,
  output logic                                out_from_crossing,
  output logic                                out_store_full,
  input  logic                                cfg_we,
  input  logic [psf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [psf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import psf_pkg::*;

  localparam int POS_W   = $clog2(RECORD_LENGTH_MAX);
  localparam int PCNT_W  = $clog2(RECORD_LENGTH_MAX + 1);
  localparam int ENTRY_W = (POS_W > PRE_W) ? POS_W : PRE_W;
  localparam int CW      = $clog2(START_STORE_DEPTH + 1);
  localparam int SW      = SAMPLE_BITS;
  localparam int CMP_W   = ((SW > THR_W + 1) ? SW : THR_W + 1) + 1;
  localparam int AW      = ((POS_W > WIN_W) ? POS_W : WIN_W) + 1;

  // configuration
  logic signed [THR_W-1:0] thr_r;
  logic [MARGIN_W-1:0]     margin_r;
  logic [WIN_W-1:0]        lookback_r;
  logic [WIN_W-1:0]        fallback_r;
  logic [NEAR_W-1:0]       near_r;

  // record state
  logic signed [SW-1:0] prev_r;
  logic signed [SW-1:0] older_r;
  logic [PCNT_W-1:0]    pos_r;
  logic [POS_W-1:0]     latest_r;
  logic                 seen_r;
  logic [CW-1:0]        count_r;

  // control and candidate
  psf_state_t         state_r;
  psf_state_t         state_nxt;
  logic [ENTRY_W-1:0] cand_r;
  logic               fromx_r;
  logic               tail_hit_r;

  logic               out_valid_r;
  logic [START_W-1:0] out_start_r;
  logic               out_fromx_r;
  logic               out_full_r;

  logic signed [SW-1:0]    cur;
  logic signed [CMP_W-1:0] cur_x, prev_x, older_x, thr_x, level_x;
  logic                    accept, is_sample, in_range, peak, cross_now;
  logic [POS_W-1:0]        pos_i;
  logic                    win_ok, from_x, fb_gt;
  logic [AW-1:0]           fb_diff;
  logic [POS_W-1:0]        t0_fb, t0;
  logic                    slot_free, emit, launch, store_full;
  logic                    store_we;
  logic [ENTRY_W-1:0]      store_wdata;
  psf_flag_t               head_flag, tail_flag;

  if (SW <= SAMPLE_IN_W) begin : g_sample_narrow
    assign cur = in_sample_value[SW-1:0];
  end else begin : g_sample_wide
    assign cur = {{(SW-SAMPLE_IN_W){1'b0}}, in_sample_value};
  end

  always_comb begin
    accept    = in_valid && in_ready;
    is_sample = in_op == OP_SAMPLE;
    cur_x     = CMP_W'(cur);
    prev_x    = CMP_W'(prev_r);
    older_x   = CMP_W'(older_r);
    thr_x     = CMP_W'(thr_r);
    level_x   = thr_x + CMP_W'($signed({1'b0, margin_r}));
    in_range  = pos_r < PCNT_W'(RECORD_LENGTH_MAX);
    pos_i     = pos_r[POS_W-1:0] - POS_W'(1);
    peak      = in_range && !in_last_sample && pos_r >= PCNT_W'(3) &&
                prev_x >= older_x && prev_x > cur_x && prev_x >= level_x;
    win_ok    = (AW'(latest_r) + AW'(lookback_r)) >= AW'(pos_i);
    from_x    = seen_r && win_ok;
    fb_gt     = AW'(pos_i) > AW'(fallback_r);
    fb_diff   = AW'(pos_i) - AW'(fallback_r);
    t0_fb     = fb_gt ? fb_diff[POS_W-1:0] : POS_W'(1);
    t0        = from_x ? latest_r : t0_fb;
    cross_now = pos_r != '0 && prev_x < thr_x && cur_x >= thr_x;
    store_full = count_r == CW'(START_STORE_DEPTH);
    slot_free  = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_sample && peak) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (tail_flag.tok) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (tail_hit_r || slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready    = rst_n && state_r == ST_IDLE;
    launch      = accept && is_sample && peak;
    emit        = state_r == ST_FINISH && !tail_hit_r && slot_free;
    store_we    = !store_full && ((accept && !is_sample) || emit);
    store_wdata = (state_r == ST_FINISH) ? cand_r : ENTRY_W'(in_preload_position);
    head_flag.tok = launch;
    head_flag.hit = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= THR_RESET;
      margin_r   <= MARGIN_RESET;
      lookback_r <= LOOKBACK_RESET;
      fallback_r <= FALLBACK_RESET;
      near_r     <= NEAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SEED_THRESHOLD:  thr_r      <= cfg_wdata[THR_W-1:0];
        REG_PEAK_MARGIN:     margin_r   <= cfg_wdata[MARGIN_W-1:0];
        REG_LOOKBACK_WINDOW: lookback_r <= cfg_wdata[WIN_W-1:0];
        REG_FALLBACK_OFFSET: fallback_r <= cfg_wdata[WIN_W-1:0];
        REG_NEAR_DISTANCE:   near_r     <= cfg_wdata[NEAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r   <= '0;
      older_r  <= '0;
      pos_r    <= '0;
      latest_r <= '0;
      seen_r   <= 1'b0;
      count_r  <= '0;
    end else if (accept && is_sample && in_last_sample) begin
      // drop the whole record after its final sample
      prev_r   <= '0;
      older_r  <= '0;
      pos_r    <= '0;
      latest_r <= '0;
      seen_r   <= 1'b0;
      count_r  <= '0;
    end else begin
      if (store_we) count_r <= count_r + CW'(1);
      if (accept && is_sample && in_range) begin
        older_r <= prev_r;
        prev_r  <= cur;
        pos_r   <= pos_r + PCNT_W'(1);
        if (cross_now) begin
          latest_r <= pos_r[POS_W-1:0];
          seen_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      cand_r  <= ENTRY_W'(t0);
      fromx_r <= from_x;
    end
    if (state_r == ST_SCAN && tail_flag.tok) tail_hit_r <= tail_flag.hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_start_r <= cand_r[START_W-1:0];
      out_fromx_r <= fromx_r;
      out_full_r  <= store_full;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_start_index   = out_start_r;
  assign out_from_crossing = out_fromx_r;
  assign out_store_full    = out_full_r;

  psf_chain #(
    .DEPTH   (START_STORE_DEPTH),
    .ENTRY_W (ENTRY_W),
    .CW      (CW)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_flag (head_flag),
    .head_cand (ENTRY_W'(t0)),
    .tail_flag (tail_flag),
    .count     (count_r),
    .near_dist (near_r),
    .we        (store_we),
    .wdata     (store_wdata)
  );

endmodule

@@ hdl/psf_checker.sv @@
// Port-level checks for the peak start candidate finder, bound to the top.
// Depends on psf_pkg and peak_start_candidate_finder.
module psf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_op,
  input logic                        in_last_sample,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [psf_pkg::START_W-1:0] out_start_index,
  input logic                        out_from_crossing,
  input logic                        out_store_full
);
  import psf_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start_index) &&
      $stable(out_from_crossing) && $stable(out_store_full))
    else $error("stalled result changed");

  a_preload_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_PRELOAD |=> in_ready)
    else $error("preload transaction did not finish in one cycle");

  a_last_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_op == OP_SAMPLE && in_last_sample |=> in_ready)
    else $error("final sample started a store scan");

  a_result_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a store scan");

endmodule

bind peak_start_candidate_finder psf_checker u_psf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_op             (in_op),
  .in_last_sample    (in_last_sample),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_start_index   (out_start_index),
  .out_from_crossing (out_from_crossing),
  .out_store_full    (out_store_full)
);

@@ tb/tb.sv @@
// Self-checking testbench for peak_start_candidate_finder: valid/ready driver
// and monitor, with a cycle-free predictor of the pulse start candidates.
// Depends on psf_pkg and the RTL in hdl/.
`timescale 1ns / 1ps

module tb;
  import psf_pkg::*;

  localparam int STORE_DEPTH   = START_STORE_DEPTH_DEF;
  localparam int REC_MAX       = RECORD_LENGTH_MAX_DEF;
  localparam int SETTLE_CYCLES = STORE_DEPTH + 2 + 40;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 60;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  typedef struct {
    logic                     op;
    logic signed [SAMPLE_IN_W-1:0] smp;
    logic [PRE_W-1:0]         pos;
    logic                     last;
  } psf_item_t;

  typedef struct packed {
    logic [START_W-1:0] start_index;
    logic               from_crossing;
    logic               store_full;
  } start_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = OP_SAMPLE;
  logic signed [SAMPLE_IN_W-1:0] in_sample_value = '0;
  logic [PRE_W-1:0] in_preload_position = '0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [START_W-1:0] out_start_index;
  logic out_from_crossing;
  logic out_store_full;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  peak_start_candidate_finder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_sample_value     (in_sample_value),
    .in_preload_position (in_preload_position),
    .in_last_sample      (in_last_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_start_index     (out_start_index),
    .out_from_crossing   (out_from_crossing),
    .out_store_full      (out_store_full),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // Predictor copy of the configuration and record state
  int thr_cfg = 35;
  int margin_cfg = 8;
  int lookback_cfg = 220;
  int fallback_cfg = 24;
  int near_cfg = 6;
  int prev_s = 0;
  int older_s = 0;
  int rec_pos = 0;
  int xing_pos = 0;
  bit xing_seen = 1'b0;
  int st_mem [STORE_DEPTH];
  int st_count = 0;

  psf_item_t  pending_items [$];
  start_res_t expected_starts [$];
  psf_item_t  nxt;
  start_res_t exp_res;
  int  queued = 0;
  int  err_count = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;

  int dir_a [14] = '{0, 50, 60, 40, 70, 20, 20, 32767, -32768, 35, 43, 43, 10, 30};
  int dir_b [5]  = '{100, 100, 120, 110, 5};
  int dir_c [4]  = '{0, 50, 90, 10};

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic signed [SAMPLE_IN_W-1:0] sat16(input int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Work out the start candidate (if any) caused by one accepted transaction
  task automatic find_start_candidate(input logic op, input logic signed [15:0] smp,
                                      input logic [11:0] pre, input logic last);
    int cur, i, lo, t0, d, k;
    bit from_x, near_hit;
    start_res_t res;
    cur = smp;
    if (op == OP_PRELOAD) begin
      if (st_count < STORE_DEPTH) begin
        st_mem[st_count] = pre;
        st_count++;
      end
    end else begin
      if (rec_pos < REC_MAX) begin
        if (!last && rec_pos >= 3) begin
          i = rec_pos - 1;
          if (prev_s >= older_s && prev_s > cur && prev_s >= thr_cfg + margin_cfg) begin
            lo = i - lookback_cfg;
            if (lo < 1) lo = 1;
            if (xing_seen && xing_pos >= lo) begin
              t0 = xing_pos;
              from_x = 1'b1;
            end else begin
              t0 = i - fallback_cfg;
              if (t0 < 1) t0 = 1;
              from_x = 1'b0;
            end
            near_hit = 1'b0;
            for (k = 0; k < st_count; k++) begin
              d = st_mem[k] - t0;
              if (d < 0) d = -d;
              if (d <= near_cfg) near_hit = 1'b1;
            end
            if (!near_hit) begin
              res.start_index   = t0[11:0];
              res.from_crossing = from_x;
              res.store_full    = (st_count >= STORE_DEPTH);
              if (!res.store_full) begin
                st_mem[st_count] = t0;
                st_count++;
              end
              expected_starts.insert(expected_starts.size(), res);
            end
          end
        end
        if (rec_pos >= 1 && prev_s < thr_cfg && cur >= thr_cfg) begin
          xing_pos  = rec_pos;
          xing_seen = 1'b1;
        end
        older_s = prev_s;
        prev_s  = cur;
        rec_pos++;
      end
      if (last) begin
        prev_s = 0;
        older_s = 0;
        rec_pos = 0;
        xing_pos = 0;
        xing_seen = 1'b0;
        st_count = 0;
      end
    end
  endtask

  // Driver: present queued items, draw a gap after each transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        find_start_candidate(in_op, in_sample_value, in_preload_position, in_last_sample);
        gap_left = idle_on ? $urandom_range(0, 3) : 0;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          in_op               <= nxt.op;
          in_sample_value     <= nxt.smp;
          in_preload_position <= nxt.pos;
          in_last_sample      <= nxt.last;
          in_valid            <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction, then may hold out_ready low before the next
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_starts.size() == 0) begin
          $error("unexpected result: start_index %0d from_crossing %0d store_full %0d",
                 out_start_index, out_from_crossing, out_store_full);
          err_count++;
        end else begin
          exp_res = expected_starts.pop_front();
          if (out_start_index !== exp_res.start_index) begin
            $error("start_index: expected %0d, got %0d", exp_res.start_index,
                   out_start_index);
            err_count++;
          end
          if (out_from_crossing !== exp_res.from_crossing) begin
            $error("from_crossing: expected %0d, got %0d", exp_res.from_crossing,
                   out_from_crossing);
            err_count++;
          end
          if (out_store_full !== exp_res.store_full) begin
            $error("store_full: expected %0d, got %0d", exp_res.store_full,
                   out_store_full);
            err_count++;
          end
        end
        stall_left = idle_on ? $urandom_range(0, 3) : 0;
      end else if (out_valid && stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  task automatic push_item(input logic op, input int smp, input int pos, input logic last);
    psf_item_t it;
    it.op   = op;
    it.smp  = sat16(smp);
    it.pos  = pos[11:0];
    it.last = last;
    pending_items.insert(pending_items.size(), it);
    queued++;
  endtask

  task automatic push_noise();
    push_item(1'($urandom_range(0, 1)), int'($urandom) >>> 16, $urandom,
              $urandom_range(0, 7) == 0);
  endtask

  // One record: baseline noise around a level below threshold with pulses of random shape,
  // optionally interleaved with preloads, some of them near the current position
  task automatic gen_record(input int len, input int pulse_odds, input int preload_odds);
    int vals [$];
    int base, peak, rise, fall, plat, j, k, pos;
    base = thr_cfg - int'($urandom_range(1, 60));
    while (vals.size() < len) begin
      if ($urandom_range(0, pulse_odds - 1) == 0) begin
        rise = $urandom_range(1, 4);
        fall = $urandom_range(1, 4);
        plat = $urandom_range(0, 2);
        if ($urandom_range(0, 19) == 0) peak = thr_cfg + int'($urandom_range(0, 65535));
        else peak = thr_cfg + int'($urandom_range(0, 400));
        for (j = 1; j <= rise; j++) vals.insert(vals.size(), base + (peak - base) * j / rise);
        repeat (plat) vals.insert(vals.size(), peak);
        for (j = fall - 1; j >= 0; j--) vals.insert(vals.size(), base + (peak - base) * j / fall);
      end else if ($urandom_range(0, 49) == 0) begin
        vals.insert(vals.size(), int'($urandom) >>> 16);
      end else begin
        vals.insert(vals.size(), base + int'($urandom_range(0, 30)) - 15);
      end
    end
    for (k = 0; k < len; k++) begin
      if (preload_odds > 0 && $urandom_range(0, preload_odds - 1) == 0) begin
        if ($urandom_range(0, 1) == 0) pos = k - int'($urandom_range(0, 12));
        else pos = $urandom;
        push_item(OP_PRELOAD, int'($urandom) >>> 16, pos, 1'($urandom_range(0, 1)));
      end
      push_item(OP_SAMPLE, vals[k], $urandom, k == len - 1);
    end
  endtask

  task automatic fill_phase(input int budget);
    int first, len;
    first = queued;
    while (queued - first < budget) begin
      if ($urandom_range(0, 11) == 0) begin
        push_noise();
      end else begin
        case ($urandom_range(0, 19))
          0, 1:    len = $urandom_range(1, 4);
          2:       len = $urandom_range(40, 200);
          default: len = $urandom_range(5, 40);
        endcase
        gen_record(len, 4, 16);
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_SEED_THRESHOLD:  thr_cfg = int'($signed(data));
      REG_PEAK_MARGIN:     margin_cfg = data[7:0];
      REG_LOOKBACK_WINDOW: lookback_cfg = data[9:0];
      REG_FALLBACK_OFFSET: fallback_cfg = data[9:0];
      REG_NEAR_DISTANCE:   near_cfg = data[5:0];
      default: ;
    endcase
  endtask

  // Write all registers; bits above each register's width carry junk
  task automatic set_config(input int thr, input int margin, input int lb, input int fb,
                            input int nd, input bit extra);
    write_reg(REG_SEED_THRESHOLD, thr[15:0]);
    write_reg(REG_PEAK_MARGIN, {8'($urandom), margin[7:0]});
    write_reg(REG_LOOKBACK_WINDOW, {6'($urandom), lb[9:0]});
    write_reg(REG_FALLBACK_OFFSET, {6'($urandom), fb[9:0]});
    write_reg(REG_NEAR_DISTANCE, {10'($urandom), nd[5:0]});
    if (extra) write_reg(REG_UNUSED, 16'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until the queue is empty and every result is in, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_starts.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int pick_window();
    if ($urandom_range(0, 2) == 0) return $urandom_range(0, 20);
    return $urandom_range(0, 1023);
  endfunction

  initial begin
    int ph, thr, margin, nd;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme fields, preload with last set, crossing start, start
    // suppressed by a preload, plateau peak, fallback start, short record
    push_item(OP_PRELOAD, -32768, 4095, 1'b1);
    push_item(OP_PRELOAD, 32767, 0, 1'b0);
    foreach (dir_a[k]) push_item(OP_SAMPLE, dir_a[k], $urandom, k == 13);
    foreach (dir_b[k]) push_item(OP_SAMPLE, dir_b[k], $urandom, k == 4);
    foreach (dir_c[k]) push_item(OP_SAMPLE, dir_c[k], $urandom, k == 3);
    wait_drained();

    for (ph = 0; ph < PHASES; ph++) begin
      thr    = int'($urandom_range(0, 400)) - 200;
      margin = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
      nd     = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 63);
      case (ph)
        0:       set_config(-32768, 0, 0, 0, 0, 1'b0);
        1:       set_config(32767, 0, 1023, 1023, 63, 1'b0);
        2:       set_config(thr, 255, pick_window(), pick_window(), nd, 1'b0);
        3:       set_config(thr, margin, pick_window(), pick_window(), 0, 1'b0);
        5:       set_config(thr, margin, pick_window(), pick_window(), nd, 1'b1);
        default: set_config(thr, margin, pick_window(), pick_window(), nd, 1'b0);
      endcase
      idle_on = (ph % 4 != 3);
      if (ph == 3) begin
        // Overfill the store with preloads, then drive peaks into it
        repeat (STORE_DEPTH + 2) push_item(OP_PRELOAD, int'($urandom) >>> 16, $urandom,
                                           1'($urandom_range(0, 1)));
        gen_record(80, 3, 0);
      end
      fill_phase(PHASE_ITEMS);
      wait_drained();
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
